// ----- rtl/madd_pkg.sv -----
// Shared types and constants for the moving-average drop detector.
// No dependencies; madd_ctrl, madd_dp and the top level import this package.
`timescale 1ns / 1ps

package madd_pkg;

	localparam int WINDOW     = 50;
	localparam int SAMPLE_W   = 10;
	localparam int SUM_W      = 16;
	localparam int THR_W      = 16;
	localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W      = $clog2(WINDOW + 1);
	localparam int DIV_CNT_W  = $clog2(SUM_W);
	localparam int PROD_W     = SAMPLE_W + THR_W;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(63570);

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_PRIME = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic                hit;
		logic [SAMPLE_W-1:0] average;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic mul;
		logic commit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/madd_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module madd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/madd_ctrl.sv -----
// Controller FSM: accept, serial divide, multiply, compare and commit.
// Depends on madd_pkg.
`timescale 1ns / 1ps

module madd_ctrl import madd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_MUL  = 2'd2;
	localparam logic [1:0] S_CMP  = 2'd3;

	logic [1:0]           state_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	assign item_ready   = (state_q == S_IDLE);
	assign cmd.load     = item_valid && item_ready;
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.mul      = (state_q == S_MUL);
	assign cmd.commit   = (state_q == S_CMP) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					// wait here until the result register can take the transfer
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/madd_dp.sv -----
// Datapath: ring storage, running sum, fill count, restoring divider,
// threshold multiply and compare, result register. Depends on madd_pkg, madd_ram.
`timescale 1ns / 1ps

module madd_dp import madd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  in_item_t         item,
	output out_item_t        result,
	output logic             result_valid,
	input  logic             result_ready,
	input  logic             cfg_valid,
	input  logic [THR_W-1:0] cfg_data
);

	logic [THR_W-1:0]    thr_q;
	logic [SUM_W-1:0]    sum_q;
	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    fill_q;
	logic                cmd_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [PROD_W-1:0]   prod_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [CNT_W:0]      trial;
	logic                take;
	logic [SAMPLE_W-1:0] avg_next;
	logic [PROD_W-1:0]   lhs;
	logic                hit;
	logic                push;
	logic [SAMPLE_W-1:0] old_val;
	logic [SAMPLE_W-1:0] rd_data;

	madd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk    (clk),
		.wr_en  (push),
		.wr_addr(pos_q),
		.wr_data(sample_q),
		.rd_en  (cmd.load),
		.rd_addr(pos_q),
		.rd_data(rd_data)
	);

	// restoring divide step: sum / fill_count, one quotient bit per cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign take  = (trial >= {1'b0, fill_q});

	assign avg_next = (fill_q == '0) ? '0 : quo_q[SAMPLE_W-1:0];
	assign lhs      = {sample_q, {THR_W{1'b0}}};
	assign hit      = (cmd_q == CMD_CHECK) && (lhs < prod_q);
	assign push     = cmd.commit && !hit;
	// slots not yet filled are read as zero; the RAM itself is not reset
	assign old_val  = (fill_q == CNT_W'(WINDOW)) ? rd_data : '0;

	assign stat.out_free = !out_valid_q || result_ready;
	assign result_valid  = out_valid_q;
	assign result        = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			sum_q       <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (push) begin
				sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
				pos_q <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
				if (fill_q < CNT_W'(WINDOW)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= item.cmd;
			sample_q <= item.sample;
			quo_q    <= sum_q;
			rem_q    <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], take};
			rem_q <= take ? CNT_W'(trial - {1'b0, fill_q}) : trial[CNT_W-1:0];
		end
		if (cmd.mul) begin
			avg_q  <= avg_next;
			prod_q <= PROD_W'(avg_next) * PROD_W'(thr_q);
		end
		if (cmd.commit) begin
			out_q.hit     <= hit;
			out_q.average <= avg_q;
		end
	end

endmodule

// ----- rtl/moving_average_drop_detector.sv -----
// Moving-average drop detector, top level. Depends on madd_pkg, madd_ctrl, madd_dp.
// An input transfer starts the serial divider steps, then the multiply and the
// compare/commit, which waits until the output register is free; one item is in
// flight at a time, and the next is taken only when the controller is back in idle.
// A finished result waits in an output register while the next item is taken.
// Reset (async, active low) empties the ring, zeroes the sum and fill count and
// loads the threshold with 63570; the ring memory needs no clearing pass.
`timescale 1ns / 1ps

module moving_average_drop_detector import madd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  in_item_t         item,
	output logic             result_valid,
	input  logic             result_ready,
	output out_item_t        result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [THR_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	madd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	madd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item        (item),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data)
	);

endmodule
